/* rtl/mst_pkg.sv */
// Shared types and constants for the multi-slot software timer core.
// No dependencies; imported by every module of the block.
package mst_pkg;

    // field widths of the beats on both channels
    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 32;

    // command codes
    localparam logic [KIND_W-1:0] KIND_SCAN   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_START  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STOP   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MODE   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd2;

    // at most this many expiries are reported per scan
    localparam int MAX_REPORTS = 16;
    localparam int CNT_W       = $clog2(MAX_REPORTS + 1);

    // tick unit operation select
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    // one result beat
    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic                fired;
        logic [STATUS_W-1:0] status;
        logic                last;
    } beat_t;

endpackage

/* rtl/mst_tick_alu.sv */
// Shared tick adder / subtractor, modulo 2^TICK_BITS.
// Depends on mst_pkg for the operation codes.
module mst_tick_alu
    import mst_pkg::*;
#(
    parameter int TICK_BITS = 32
) (
    input  logic [TICK_BITS-1:0] op_a,
    input  logic [TICK_BITS-1:0] op_b,
    input  logic                 op_sel,
    output logic [TICK_BITS-1:0] result
);

    // sum or difference, wrapping at the tick width
    always_comb begin
        if (op_sel == ALU_SUB) begin
            result = op_a - op_b;
        end else begin
            result = op_a + op_b;
        end
    end

endmodule

/* rtl/mst_out_stage.sv */
// Output register for result beats, decoupling the sequencer from m_ready.
// Depends on mst_pkg for the beat type.
module mst_out_stage
    import mst_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                beat_valid,
    input  beat_t               beat,
    output logic                beat_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SLOT_W-1:0]   m_result_slot,
    output logic                m_fired,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_last
);

    logic  valid_reg;
    beat_t data_reg;

    // room when empty or when the held beat leaves this cycle
    assign beat_ready = !valid_reg || m_ready;

    // occupancy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (beat_ready) begin
            valid_reg <= beat_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (beat_valid && beat_ready) begin
            data_reg <= beat;
        end
    end

    assign m_valid       = valid_reg;
    assign m_result_slot = data_reg.slot;
    assign m_fired       = data_reg.fired;
    assign m_status      = data_reg.status;
    assign m_last        = data_reg.last;

endmodule

/* rtl/mst_ctrl.sv */
// Command sequencer, slot flags and deadline/period memories.
// Depends on mst_pkg; drives the shared tick unit and the output stage.
module mst_ctrl
    import mst_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int TICK_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [KIND_W-1:0]    s_kind,
    input  logic [SLOT_W-1:0]    s_slot,
    input  logic [FIELD_W-1:0]   s_interval,
    input  logic                 s_periodic_flag,
    input  logic [FIELD_W-1:0]   s_now,
    output logic [TICK_BITS-1:0] alu_a,
    output logic [TICK_BITS-1:0] alu_b,
    output logic                 alu_sel,
    input  logic [TICK_BITS-1:0] alu_result,
    output logic                 beat_valid,
    output beat_t                beat,
    input  logic                 beat_ready
);

    localparam int               IDX_W    = $clog2(NUM_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CMD    = 3'd1;
    localparam logic [2:0] ST_ALLOC  = 3'd2;
    localparam logic [2:0] ST_SC_RD  = 3'd3;
    localparam logic [2:0] ST_SC_CMP = 3'd4;
    localparam logic [2:0] ST_SC_ADD = 3'd5;
    localparam logic [2:0] ST_SC_END = 3'd6;
    localparam logic [2:0] ST_RESP   = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     rcnt_reg, rcnt_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic [SLOT_W-1:0]    hold_slot_reg, hold_slot_next;
    logic [NUM_SLOTS-1:0] in_use_reg, in_use_next;
    logic [NUM_SLOTS-1:0] running_reg, running_next;
    logic [NUM_SLOTS-1:0] periodic_reg, periodic_next;
    logic [NUM_SLOTS-1:0] pend_reg, pend_next;
    beat_t                resp_reg, resp_next;

    logic [KIND_W-1:0]    kind_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [TICK_BITS-1:0] interval_reg;
    logic [TICK_BITS-1:0] now_reg;
    logic                 pflag_reg;

    logic [TICK_BITS-1:0] deadline_mem [NUM_SLOTS];
    logic [TICK_BITS-1:0] period_mem   [NUM_SLOTS];
    logic [TICK_BITS-1:0] dl_q_reg;
    logic [TICK_BITS-1:0] per_q_reg;

    logic                 accept;
    logic [IDX_W-1:0]     cmd_idx;
    logic                 cmd_hit;
    logic                 last_slot;
    logic                 fire;
    logic                 report;
    logic                 advance;
    logic                 rd_en;
    logic                 dl_we;
    logic                 per_we;
    logic [IDX_W-1:0]     wr_idx;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cmd_idx   = IDX_W'(slot_reg);
    assign cmd_hit   = (32'(slot_reg) < NUM_SLOTS) && in_use_reg[cmd_idx];
    assign last_slot = (idx_reg == LAST_IDX);
    // wrap-safe test: deadline reached when now - deadline has a clear top bit
    assign fire      = running_reg[idx_reg] && !alu_result[TICK_BITS-1];
    assign report    = (rcnt_reg < CNT_W'(MAX_REPORTS));

    // sequencer
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        rcnt_next       = rcnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        in_use_next     = in_use_reg;
        running_next    = running_reg;
        periodic_next   = periodic_reg;
        pend_next       = pend_reg;
        resp_next       = resp_reg;
        alu_a           = now_reg;
        alu_b           = interval_reg;
        alu_sel         = ALU_ADD;
        rd_en           = 1'b0;
        dl_we           = 1'b0;
        per_we          = 1'b0;
        wr_idx          = cmd_idx;
        beat_valid      = 1'b0;
        beat            = '{slot: '0, fired: 1'b0, status: STATUS_OK, last: 1'b1};
        advance         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_next = '0;
                    if (s_kind == KIND_SCAN) begin
                        // free the slots marked for deletion before the sweep
                        in_use_next     = in_use_reg & ~pend_reg;
                        running_next    = running_reg & ~pend_reg;
                        periodic_next   = periodic_reg & ~pend_reg;
                        pend_next       = '0;
                        rcnt_next       = '0;
                        hold_valid_next = 1'b0;
                        state_next      = ST_SC_RD;
                    end else if (s_kind == KIND_ALLOC) begin
                        state_next = ST_ALLOC;
                    end else begin
                        state_next = ST_CMD;
                    end
                end
            end

            ST_CMD: begin
                resp_next = '{slot: slot_reg, fired: 1'b0, status: STATUS_OK, last: 1'b1};
                if (kind_reg > KIND_DELETE) begin
                    // unknown command: echo only
                end else if (!cmd_hit) begin
                    resp_next.status = STATUS_NOT_ALLOC;
                end else begin
                    unique case (kind_reg)
                        KIND_START: begin
                            per_we                = 1'b1;
                            dl_we                 = 1'b1;
                            running_next[cmd_idx] = 1'b1;
                        end
                        KIND_STOP: begin
                            running_next[cmd_idx] = 1'b0;
                        end
                        KIND_MODE: begin
                            periodic_next[cmd_idx] = pflag_reg;
                        end
                        default: begin
                            running_next[cmd_idx] = 1'b0;
                            pend_next[cmd_idx]    = 1'b1;
                        end
                    endcase
                end
                state_next = ST_RESP;
            end

            ST_ALLOC: begin
                // lowest free slot, one slot per cycle
                if (!in_use_reg[idx_reg]) begin
                    in_use_next[idx_reg]   = 1'b1;
                    running_next[idx_reg]  = 1'b0;
                    periodic_next[idx_reg] = 1'b0;
                    pend_next[idx_reg]     = 1'b0;
                    resp_next  = '{slot: SLOT_W'(idx_reg), fired: 1'b0,
                                   status: STATUS_OK, last: 1'b1};
                    state_next = ST_RESP;
                end else if (last_slot) begin
                    resp_next  = '{slot: '0, fired: 1'b0,
                                   status: STATUS_NO_FREE, last: 1'b1};
                    state_next = ST_RESP;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_SC_RD: begin
                rd_en      = 1'b1;
                state_next = ST_SC_CMP;
            end

            ST_SC_CMP: begin
                alu_a   = now_reg;
                alu_b   = dl_q_reg;
                alu_sel = ALU_SUB;
                if (!fire) begin
                    advance = 1'b1;
                end else if (report && hold_valid_reg && !beat_ready) begin
                    // held expiry cannot leave yet
                end else begin
                    // send the previous expiry, keep this one back for the last flag
                    if (report) begin
                        if (hold_valid_reg) begin
                            beat_valid = 1'b1;
                            beat = '{slot: hold_slot_reg, fired: 1'b1,
                                     status: STATUS_OK, last: 1'b0};
                        end
                        hold_valid_next = 1'b1;
                        hold_slot_next  = SLOT_W'(idx_reg);
                        rcnt_next       = rcnt_reg + CNT_W'(1);
                    end
                    if (periodic_reg[idx_reg]) begin
                        state_next = ST_SC_ADD;
                    end else begin
                        running_next[idx_reg] = 1'b0;
                        advance               = 1'b1;
                    end
                end
            end

            ST_SC_ADD: begin
                alu_a   = dl_q_reg;
                alu_b   = per_q_reg;
                alu_sel = ALU_ADD;
                dl_we   = 1'b1;
                wr_idx  = idx_reg;
                advance = 1'b1;
            end

            ST_SC_END: begin
                if (beat_ready) begin
                    beat_valid = 1'b1;
                    if (hold_valid_reg) begin
                        beat = '{slot: hold_slot_reg, fired: 1'b1,
                                 status: STATUS_OK, last: 1'b1};
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_RESP: begin
                if (beat_ready) begin
                    beat_valid = 1'b1;
                    beat       = resp_reg;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // step to the next slot of the sweep
        if (advance) begin
            if (last_slot) begin
                state_next = ST_SC_END;
            end else begin
                idx_next   = idx_reg + IDX_W'(1);
                state_next = ST_SC_RD;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            rcnt_reg       <= '0;
            hold_valid_reg <= 1'b0;
            in_use_reg     <= '0;
            running_reg    <= '0;
            periodic_reg   <= '0;
            pend_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            rcnt_reg       <= rcnt_next;
            hold_valid_reg <= hold_valid_next;
            in_use_reg     <= in_use_next;
            running_reg    <= running_next;
            periodic_reg   <= periodic_next;
            pend_reg       <= pend_next;
        end
    end

    // command payload and held results
    always_ff @(posedge aclk) begin
        hold_slot_reg <= hold_slot_next;
        resp_reg      <= resp_next;
        if (accept) begin
            kind_reg     <= s_kind;
            slot_reg     <= s_slot;
            interval_reg <= TICK_BITS'(s_interval);
            now_reg      <= TICK_BITS'(s_now);
            pflag_reg    <= s_periodic_flag;
        end
    end

    // deadline memory: one write port, registered read
    always_ff @(posedge aclk) begin
        if (dl_we) begin
            deadline_mem[wr_idx] <= alu_result;
        end
        if (rd_en) begin
            dl_q_reg <= deadline_mem[idx_reg];
        end
    end

    // period memory: written by start only
    always_ff @(posedge aclk) begin
        if (per_we) begin
            period_mem[wr_idx] <= interval_reg;
        end
        if (rd_en) begin
            per_q_reg <= period_mem[idx_reg];
        end
    end

endmodule

/* rtl/multi_slot_software_timer_core.sv */
// Multi-slot software timer: a table of NUM_SLOTS one-shot or periodic timers driven
// by one command beat at a time (scan, allocate, start, stop, set mode, delete).
// The block takes one command, works on it and takes the next once its last beat has
// moved into the output register. A scan visits every slot in turn through one shared
// tick adder and the deadline memory: it reads each deadline, compares it with now and,
// for a periodic expiry, adds the period; a held expiry that cannot leave stalls the
// sweep. Allocate searches one slot per cycle. Expiries come out in ascending slot
// order, at most sixteen per scan, with last on the final beat.
// Depends on mst_pkg, mst_ctrl, mst_tick_alu and mst_out_stage.
module multi_slot_software_timer_core
    import mst_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int TICK_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [KIND_W-1:0]   s_kind,
    input  logic [SLOT_W-1:0]   s_slot,
    input  logic [FIELD_W-1:0]  s_interval,
    input  logic                s_periodic_flag,
    input  logic [FIELD_W-1:0]  s_now,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SLOT_W-1:0]   m_result_slot,
    output logic                m_fired,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_last
);

    logic [TICK_BITS-1:0] alu_a;
    logic [TICK_BITS-1:0] alu_b;
    logic                 alu_sel;
    logic [TICK_BITS-1:0] alu_result;
    logic                 beat_valid;
    logic                 beat_ready;
    beat_t                beat;

    // sequencer with slot state
    mst_ctrl #(
        .NUM_SLOTS (NUM_SLOTS),
        .TICK_BITS (TICK_BITS)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_slot          (s_slot),
        .s_interval      (s_interval),
        .s_periodic_flag (s_periodic_flag),
        .s_now           (s_now),
        .alu_a           (alu_a),
        .alu_b           (alu_b),
        .alu_sel         (alu_sel),
        .alu_result      (alu_result),
        .beat_valid      (beat_valid),
        .beat            (beat),
        .beat_ready      (beat_ready)
    );

    // shared tick arithmetic
    mst_tick_alu #(
        .TICK_BITS (TICK_BITS)
    ) u_alu (
        .op_a   (alu_a),
        .op_b   (alu_b),
        .op_sel (alu_sel),
        .result (alu_result)
    );

    // result register
    mst_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .beat_valid    (beat_valid),
        .beat          (beat),
        .beat_ready    (beat_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_slot (m_result_slot),
        .m_fired       (m_fired),
        .m_status      (m_status),
        .m_last        (m_last)
    );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for multi_slot_software_timer_core: drives command beats and
// checks every result beat against an in-bench model of the timer slot table or typed values.
// Depends on mst_pkg and the core RTL only.
module tb;
    import mst_pkg::*;

    localparam int SLOTS      = 16;
    localparam int TICK_W     = 32;
    localparam int SCAN_LAT   = 3 * SLOTS + 2;
    localparam int PHASE_CMDS = 72;

    // kinds with no command behind them
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] interval;
        logic               pflag;
        logic [FIELD_W-1:0] now;
    } timer_cmd_t;

    typedef struct packed {
        timer_cmd_t          cmd;
        logic                typed;
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
    } dir_row_t;

    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [KIND_W-1:0]   s_kind          = '0;
    logic [SLOT_W-1:0]   s_slot          = '0;
    logic [FIELD_W-1:0]  s_interval      = '0;
    logic                s_periodic_flag = 1'b0;
    logic [FIELD_W-1:0]  s_now           = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [SLOT_W-1:0]   m_result_slot;
    logic                m_fired;
    logic [STATUS_W-1:0] m_status;
    logic                m_last;

    // model of the slot table
    logic              tmr_in_use   [SLOTS];
    logic              tmr_running  [SLOTS];
    logic              tmr_periodic [SLOTS];
    logic              tmr_pending  [SLOTS];
    logic [TICK_W-1:0] tmr_deadline [SLOTS];
    logic [TICK_W-1:0] tmr_period   [SLOTS];

    beat_t    due_beats[$];
    dir_row_t dir_rows[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatches     = 0;
    int n_sent         = 0;
    int n_beats        = 0;
    int n_expiry_beats = 0;
    int most_expiries  = 0;
    int n_no_free      = 0;
    int n_unalloc      = 0;

    multi_slot_software_timer_core #(
        .NUM_SLOTS(SLOTS),
        .TICK_BITS(TICK_W)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_slot         (s_slot),
        .s_interval     (s_interval),
        .s_periodic_flag(s_periodic_flag),
        .s_now          (s_now),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_slot  (m_result_slot),
        .m_fired        (m_fired),
        .m_status       (m_status),
        .m_last         (m_last)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void timer_clear(input int i);
        tmr_in_use[i]   = 1'b0;
        tmr_running[i]  = 1'b0;
        tmr_periodic[i] = 1'b0;
        tmr_pending[i]  = 1'b0;
        tmr_deadline[i] = '0;
        tmr_period[i]   = '0;
    endfunction

    // apply one command to the slot table and queue the beats it is due to give
    function automatic void timer_step(input timer_cmd_t c);
        int                i;
        int                n;
        beat_t             b;
        beat_t             held;
        logic              have_held;
        logic [TICK_W-1:0] lag;
        n         = 0;
        have_held = 1'b0;
        b.slot    = c.slot;
        b.fired   = 1'b0;
        b.status  = STATUS_OK;
        b.last    = 1'b1;
        if (c.kind == KIND_SCAN) begin
            // deletions take effect before any deadline is looked at
            for (i = 0; i < SLOTS; i++)
                if (tmr_pending[i])
                    timer_clear(i);
            // wrap-safe expiry: now at or past the deadline within half the tick range
            for (i = 0; i < SLOTS; i++) begin
                lag = c.now - tmr_deadline[i];
                if (tmr_running[i] && !lag[TICK_W-1]) begin
                    if (tmr_periodic[i])
                        tmr_deadline[i] = tmr_deadline[i] + tmr_period[i];
                    else
                        tmr_running[i] = 1'b0;
                    if (n < MAX_REPORTS) begin
                        if (have_held)
                            due_beats.push_back(held);
                        held.slot   = i[SLOT_W-1:0];
                        held.fired  = 1'b1;
                        held.status = STATUS_OK;
                        held.last   = 1'b0;
                        have_held   = 1'b1;
                        n++;
                    end
                end
            end
            if (n > most_expiries)
                most_expiries = n;
            if (have_held) begin
                held.last = 1'b1;
                due_beats.push_back(held);
            end else begin
                b.slot = '0;
                due_beats.push_back(b);
            end
        end else if (c.kind == KIND_ALLOC) begin
            // lowest free slot wins
            b.slot   = '0;
            b.status = STATUS_NO_FREE;
            for (i = SLOTS - 1; i >= 0; i--)
                if (!tmr_in_use[i]) begin
                    b.slot   = i[SLOT_W-1:0];
                    b.status = STATUS_OK;
                end
            if (b.status == STATUS_OK) begin
                timer_clear(int'(b.slot));
                tmr_in_use[b.slot] = 1'b1;
            end else begin
                n_no_free++;
            end
            due_beats.push_back(b);
        end else if (c.kind > KIND_DELETE) begin
            due_beats.push_back(b);
        end else if (!tmr_in_use[c.slot]) begin
            b.status = STATUS_NOT_ALLOC;
            n_unalloc++;
            due_beats.push_back(b);
        end else begin
            case (c.kind)
                KIND_START: begin
                    tmr_period[c.slot]   = c.interval;
                    tmr_deadline[c.slot] = c.now + c.interval;
                    tmr_running[c.slot]  = 1'b1;
                end
                KIND_STOP: begin
                    tmr_running[c.slot] = 1'b0;
                end
                KIND_MODE: begin
                    tmr_periodic[c.slot] = c.pflag;
                end
                KIND_DELETE: begin
                    tmr_running[c.slot] = 1'b0;
                    tmr_pending[c.slot] = 1'b1;
                end
                default: ;
            endcase
            due_beats.push_back(b);
        end
    endfunction

    // present one command beat, with a random gap first, and predict it once accepted
    task automatic send(input timer_cmd_t c, output int added);
        int queued_cnt;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= c.kind;
        s_slot          <= c.slot;
        s_interval      <= c.interval;
        s_periodic_flag <= c.pflag;
        s_now           <= c.now;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        queued_cnt = due_beats.size();
        timer_step(c);
        added = due_beats.size() - queued_cnt;
        if (c.kind <= KIND_DELETE)
            n_sent++;
    endtask

    // hold off until every due beat has arrived and the block has settled
    task automatic drain();
        s_valid <= 1'b0;
        while (due_beats.size() != 0)
            @(posedge aclk);
        repeat (SCAN_LAT + 4) @(posedge aclk);
    endtask

    task automatic add_row(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                           input logic [FIELD_W-1:0] interval, input logic pflag,
                           input logic [FIELD_W-1:0] now, input logic typed,
                           input logic [SLOT_W-1:0] exp_slot,
                           input logic [STATUS_W-1:0] exp_status);
        dir_row_t row;
        row.cmd.kind     = kind;
        row.cmd.slot     = slot;
        row.cmd.interval = interval;
        row.cmd.pflag    = pflag;
        row.cmd.now      = now;
        row.typed        = typed;
        row.slot         = exp_slot;
        row.status       = exp_status;
        dir_rows.push_back(row);
    endtask

    // result side: random back-pressure and in-order comparison
    always @(posedge aclk) begin : result_check
        beat_t want;
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            n_beats++;
            if (m_fired)
                n_expiry_beats++;
            if (due_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat slot %0d fired %0b status %0d last %0b",
                             $realtime, m_result_slot, m_fired, m_status, m_last);
            end else begin
                want = due_beats.pop_front();
                if (m_result_slot !== want.slot || m_fired !== want.fired ||
                    m_status !== want.status || m_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: beat mismatch, expected slot %0d fired %0b status %0d",
                                  " last %0b, got slot %0d fired %0b status %0d last %0b"},
                                 $realtime, want.slot, want.fired, want.status, want.last,
                                 m_result_slot, m_fired, m_status, m_last);
                end
            end
        end
    end

    initial begin : stimulus
        timer_cmd_t        c;
        beat_t             typed_b;
        logic [TICK_W-1:0] tick_now;
        int                added;
        int                start_cnt;
        int                nfree;
        int                i;
        int                j;
        int                k;
        int                p;
        int                r;
        int                sel;
        logic              picked;

        for (i = 0; i < SLOTS; i++)
            timer_clear(i);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, refusals, spare kinds, tick extremes, half-range edge,
        // periodic with zero period, commands on a slot awaiting deletion
        add_row(KIND_SCAN,     4'd0,  32'd0,         1'b0, 32'd0,         1'b1, 4'd0,  STATUS_OK);
        add_row(KIND_START,    4'd3,  32'd7,         1'b1, 32'd9,         1'b1, 4'd3,
                STATUS_NOT_ALLOC);
        add_row(KIND_DELETE,   4'd15, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 4'd15,
                STATUS_NOT_ALLOC);
        add_row(KIND_SPARE_LO, 4'd9,  32'd0,         1'b0, 32'd0,         1'b1, 4'd9,  STATUS_OK);
        add_row(KIND_SPARE_HI, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 4'd15, STATUS_OK);
        add_row(KIND_ALLOC,    4'd7,  32'd0,         1'b0, 32'd0,         1'b1, 4'd0,  STATUS_OK);
        add_row(KIND_ALLOC,    4'd0,  32'd0,         1'b0, 32'd0,         1'b1, 4'd1,  STATUS_OK);
        add_row(KIND_ALLOC,    4'd0,  32'd0,         1'b0, 32'd0,         1'b1, 4'd2,  STATUS_OK);
        add_row(KIND_MODE,     4'd1,  32'd0,         1'b1, 32'd0,         1'b1, 4'd1,  STATUS_OK);
        add_row(KIND_START,    4'd0,  32'hFFFF_FFFF, 1'b0, 32'd0,         1'b1, 4'd0,  STATUS_OK);
        add_row(KIND_START,    4'd1,  32'd0,         1'b0, 32'hFFFF_FFFF, 1'b1, 4'd1,  STATUS_OK);
        add_row(KIND_START,    4'd2,  32'h8000_0000, 1'b0, 32'h7FFF_FFFF, 1'b1, 4'd2,  STATUS_OK);
        add_row(KIND_SCAN,     4'd0,  32'd0,         1'b0, 32'hFFFF_FFFE, 1'b0, 4'd0,  STATUS_OK);
        add_row(KIND_SCAN,     4'd0,  32'd0,         1'b0, 32'h7FFF_FFFE, 1'b0, 4'd0,  STATUS_OK);
        add_row(KIND_SCAN,     4'd0,  32'd0,         1'b0, 32'h7FFF_FFFF, 1'b0, 4'd0,  STATUS_OK);
        add_row(KIND_DELETE,   4'd1,  32'd0,         1'b0, 32'd0,         1'b1, 4'd1,  STATUS_OK);
        add_row(KIND_START,    4'd1,  32'd5,         1'b0, 32'd0,         1'b1, 4'd1,  STATUS_OK);
        add_row(KIND_MODE,     4'd1,  32'd0,         1'b0, 32'd0,         1'b1, 4'd1,  STATUS_OK);
        add_row(KIND_SCAN,     4'd0,  32'd0,         1'b0, 32'd100,       1'b0, 4'd0,  STATUS_OK);
        add_row(KIND_STOP,     4'd1,  32'd0,         1'b0, 32'd0,         1'b1, 4'd1,
                STATUS_NOT_ALLOC);
        add_row(KIND_ALLOC,    4'd0,  32'd0,         1'b0, 32'd0,         1'b1, 4'd1,  STATUS_OK);
        add_row(KIND_STOP,     4'd0,  32'd0,         1'b0, 32'd0,         1'b1, 4'd0,  STATUS_OK);
        add_row(KIND_SCAN,     4'd0,  32'd0,         1'b0, 32'd0,         1'b0, 4'd0,  STATUS_OK);

        for (k = 0; k < dir_rows.size(); k++) begin
            send(dir_rows[k].cmd, added);
            // rows with a value typed in replace what the model predicted
            if (dir_rows[k].typed) begin
                repeat (added) void'(due_beats.pop_back());
                typed_b.slot   = dir_rows[k].slot;
                typed_b.fired  = 1'b0;
                typed_b.status = dir_rows[k].status;
                typed_b.last   = 1'b1;
                due_beats.push_back(typed_b);
            end
        end
        drain();

        // random phases with different idling on each side
        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
                default: begin src_idle_pct = 22; sink_stall_pct = 22; end
            endcase
            // one phase starts just short of the tick wrap
            tick_now  = (p == 2) ? 32'hFFFF_FF00 : $urandom;
            start_cnt = n_sent;
            while (n_sent - start_cnt < PHASE_CMDS) begin
                c.interval = $urandom;
                c.pflag    = 1'($urandom_range(1));
                c.now      = tick_now;
                if ($urandom_range(99) < 10) begin
                    // fill the table plus one refused allocate, start all, expire all
                    nfree = 0;
                    for (i = 0; i < SLOTS; i++)
                        if (!tmr_in_use[i])
                            nfree++;
                    c.kind = KIND_ALLOC;
                    c.slot = SLOT_W'($urandom_range(SLOTS - 1));
                    repeat (nfree + 1) send(c, added);
                    for (i = 0; i < SLOTS; i++)
                        if (tmr_in_use[i]) begin
                            c.kind     = KIND_START;
                            c.slot     = i[SLOT_W-1:0];
                            c.interval = $urandom_range(20);
                            c.now      = tick_now;
                            send(c, added);
                        end
                    tick_now = tick_now + 21;
                    c.kind   = KIND_SCAN;
                    c.now    = tick_now;
                    send(c, added);
                end else begin
                    // mostly address slots that are in use
                    c.slot = SLOT_W'($urandom_range(SLOTS - 1));
                    picked = 1'b0;
                    if ($urandom_range(99) < 85)
                        for (i = 0; i < SLOTS; i++) begin
                            j = (c.slot + i) % SLOTS;
                            if (tmr_in_use[j] && !picked) begin
                                c.slot = j[SLOT_W-1:0];
                                picked = 1'b1;
                            end
                        end
                    r = $urandom_range(99);
                    if (r < 24) begin
                        c.kind   = KIND_SCAN;
                        tick_now = tick_now + $urandom_range(12);
                        c.now    = ($urandom_range(19) == 0) ? $urandom : tick_now;
                    end else if (r < 38) begin
                        c.kind = KIND_ALLOC;
                    end else if (r < 62) begin
                        c.kind = KIND_START;
                        sel    = $urandom_range(9);
                        if (sel == 0)
                            c.interval = '0;
                        else if (sel != 1)
                            c.interval = $urandom_range(1, 40);
                    end else if (r < 70) begin
                        c.kind = KIND_STOP;
                    end else if (r < 82) begin
                        c.kind = KIND_MODE;
                    end else if (r < 96) begin
                        c.kind = KIND_DELETE;
                    end else begin
                        c.kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
                    end
                    send(c, added);
                end
            end
            // let everything drain before the next phase
            drain();
        end

        $display("covered %0d commands and %0d result beats, %0d of them expiries",
                 n_sent, n_beats, n_expiry_beats);
        $display("largest scan fired %0d slots; %0d full-table and %0d unallocated-slot refusals",
                 most_expiries, n_no_free, n_unalloc);
        if (mismatches == 0 && due_beats.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
